// ----- rtl/acs_pkg.sv -----
// Shared types and constants of the ATA PIO command sequencer.
// Used by acs_ctrl, acs_emit and ata_pio_command_sequencer_top; no dependencies.
`default_nettype none
package acs_pkg;

  // Input item kinds.
  typedef enum logic [1:0] {
    OPC_START     = 2'd0,
    OPC_REPLY     = 2'd1,
    OPC_TICK      = 2'd2,
    OPC_XFER_DONE = 2'd3
  } opcode_t;

  // Bus operations carried by a result item.
  typedef enum logic [2:0] {
    BOP_READ  = 3'd0,
    BOP_WRITE = 3'd1,
    BOP_IN    = 3'd2,
    BOP_OUT   = 3'd3,
    BOP_DONE  = 3'd4,
    BOP_WAIT  = 3'd5
  } bus_op_t;

  // Completion codes.
  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_DEV_ERR = 2'd1;
  localparam logic [1:0] RC_TIMEOUT = 2'd2;
  localparam logic [1:0] RC_PHASE   = 2'd3;

  // Task-file register indexes in ATA order.
  localparam logic [3:0] REG_DATA       = 4'd0;
  localparam logic [3:0] REG_FEATURES   = 4'd1;
  localparam logic [3:0] REG_IREASON    = 4'd2;
  localparam logic [3:0] REG_BCL        = 4'd4;
  localparam logic [3:0] REG_BCH        = 4'd5;
  localparam logic [3:0] REG_DEVHEAD    = 4'd6;
  localparam logic [3:0] REG_STATUS     = 4'd7;
  localparam logic [3:0] REG_ALT_STATUS = 4'd8;

  // Status and interrupt reason bit positions.
  localparam int ST_BSY_BIT = 7;
  localparam int ST_DRQ_BIT = 3;
  localparam int ST_ERR_BIT = 0;
  localparam int DEV_BIT    = 4;
  localparam int IR_COD_BIT = 0;
  localparam int IR_IO_BIT  = 1;

  // Command bytes with a known protocol.
  localparam logic [7:0] CMD_FLUSH_E5    = 8'hE5;
  localparam logic [7:0] CMD_FLUSH_E6    = 8'hE6;
  localparam logic [7:0] CMD_IDENTIFY    = 8'hEC;
  localparam logic [7:0] CMD_IDENT_PKT   = 8'hA1;
  localparam logic [7:0] CMD_READ_SECT   = 8'h20;
  localparam logic [7:0] CMD_WRITE_SECT  = 8'h30;
  localparam logic [7:0] CMD_PACKET      = 8'hA0;
  localparam logic [7:0] CMD_DIAGNOSTIC  = 8'h90;

  // Protocol classes.
  localparam logic [2:0] PC_UNKNOWN = 3'd0;
  localparam logic [2:0] PC_NONDATA = 3'd1;
  localparam logic [2:0] PC_PIO_IN  = 3'd2;
  localparam logic [2:0] PC_PIO_OUT = 3'd3;
  localparam logic [2:0] PC_PACKET  = 3'd4;
  localparam logic [2:0] PC_DIAG    = 3'd5;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PKT_WORDS = 1'b1;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd500;
  localparam logic [3:0]  PKT_WORDS_RESET = 4'd6;

  localparam int WORDS_W      = 17;
  localparam int TF_W         = 57;
  localparam int SECTOR_SHIFT = 8;   // 256 words per sector
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  // Sequencer phases, one-hot.
  typedef enum logic [16:0] {
    PH_IDLE         = 17'h00001,
    PH_BI_STAT      = 17'h00002,
    PH_BI_DEV       = 17'h00004,
    PH_CMD_STAT     = 17'h00008,
    PH_XFER_IN      = 17'h00010,
    PH_IN_ALT       = 17'h00020,
    PH_XFER_OUT     = 17'h00040,
    PH_PKT_REASON_A = 17'h00080,
    PH_PKT_SEND     = 17'h00100,
    PH_PKT_ALT      = 17'h00200,
    PH_PKT_STAT     = 17'h00400,
    PH_PKT_REASON_B = 17'h00800,
    PH_PKT_BCL_IN   = 17'h01000,
    PH_PKT_BCH_IN   = 17'h02000,
    PH_PKT_BCL_OUT  = 17'h04000,
    PH_PKT_BCH_OUT  = 17'h08000,
    PH_PKT_XFER     = 17'h10000
  } phase_t;

  // Shape of the result burst that one input item causes.
  typedef enum logic [1:0] {
    DK_SINGLE   = 2'd0,
    DK_RESEL    = 2'd1,
    DK_TASKFILE = 2'd2
  } desc_kind_t;

  typedef struct packed {
    bus_op_t     op;
    logic [3:0]  reg_index;
    logic [7:0]  write_value;
    logic [15:0] word_count;
    logic [1:0]  result_code;
  } result_t;

  typedef struct packed {
    desc_kind_t       kind;
    result_t          res;
    logic [TF_W-1:0]  tf;
  } desc_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  command_code;
    logic [7:0]  features;
    logic [7:0]  sector_count;
    logic [27:0] lba;
    logic        drive;
    logic [7:0]  head_bits;
    logic [7:0]  reply_value;
  } item_t;

  function automatic result_t mk_read(input logic [3:0] idx);
    result_t r;
    r = '{op: BOP_READ, reg_index: idx, write_value: 8'd0, word_count: 16'd0,
          result_code: RC_OK};
    return r;
  endfunction

  function automatic result_t mk_write(input logic [3:0] idx, input logic [7:0] val);
    result_t r;
    r = '{op: BOP_WRITE, reg_index: idx, write_value: val, word_count: 16'd0,
          result_code: RC_OK};
    return r;
  endfunction

  function automatic result_t mk_xfer(input bus_op_t op, input logic [15:0] wc);
    result_t r;
    r = '{op: op, reg_index: REG_DATA, write_value: 8'd0, word_count: wc,
          result_code: RC_OK};
    return r;
  endfunction

  function automatic result_t mk_done(input logic [1:0] code);
    result_t r;
    r = '{op: BOP_DONE, reg_index: REG_DATA, write_value: 8'd0, word_count: 16'd0,
          result_code: code};
    return r;
  endfunction

  function automatic result_t mk_wait();
    result_t r;
    r = '{op: BOP_WAIT, reg_index: REG_DATA, write_value: 8'd0, word_count: 16'd0,
          result_code: RC_OK};
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/acs_ctrl.sv -----
// Protocol state and decision logic: updates the sequencer state on each
// accepted item and describes the result burst it causes. Depends on acs_pkg.
`default_nettype none
module acs_ctrl #(
  parameter int BLOCK_WORDS = 256
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                accept,
  input  acs_pkg::item_t                     item,
  input  wire                                cfg_we,
  input  wire [acs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [acs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output acs_pkg::desc_t                     desc
);

  localparam logic [acs_pkg::WORDS_W-1:0] BLK = acs_pkg::WORDS_W'(BLOCK_WORDS);

  logic [15:0]                  timeout_ticks;
  logic [3:0]                   packet_words;

  acs_pkg::phase_t              phase, phase_next;
  logic [2:0]                   protocol_class, protocol_class_next;
  logic [acs_pkg::WORDS_W-1:0]  words_left, words_left_next;
  logic [15:0]                  wait_ticks, wait_ticks_next;
  logic [acs_pkg::TF_W-1:0]     taskfile, taskfile_next;
  logic [7:0]                   byte_count_low, byte_count_low_next;

  logic [acs_pkg::WORDS_W-1:0]  blk_size;
  logic [acs_pkg::WORDS_W-1:0]  words_after;
  logic [15:0]                  ticks_inc;
  logic [7:0]                   v;
  logic [7:0]                   head;
  logic [1:0]                   err_code;
  logic [8:0]                   sectors;
  logic [16:0]                  bc_round;
  acs_pkg::result_t             res;
  acs_pkg::desc_kind_t          kind;

  always_comb begin
    v           = item.reply_value;
    head        = taskfile[47:40];
    err_code    = {1'b0, v[acs_pkg::ST_ERR_BIT]};
    blk_size    = (words_left > BLK) ? BLK : words_left;
    words_after = words_left - blk_size;
    ticks_inc   = (wait_ticks != acs_pkg::TICKS_MAX) ? wait_ticks + 16'd1 : wait_ticks;
    sectors     = (item.sector_count == 8'd0) ? 9'd256 : {1'b0, item.sector_count};
    bc_round    = {1'b0, v, byte_count_low} + 17'd1;

    phase_next          = phase;
    protocol_class_next = protocol_class;
    words_left_next     = words_left;
    wait_ticks_next     = wait_ticks;
    taskfile_next       = taskfile;
    byte_count_low_next = byte_count_low;
    kind                = acs_pkg::DK_SINGLE;
    res                 = acs_pkg::mk_wait();

    case (item.opcode)
      acs_pkg::OPC_START: begin
        if (phase == acs_pkg::PH_IDLE) begin
          taskfile_next = {item.drive, item.command_code, item.head_bits,
                           item.lba[23:0], item.sector_count, item.features};
          case (item.command_code)
            acs_pkg::CMD_FLUSH_E5, acs_pkg::CMD_FLUSH_E6:
              protocol_class_next = acs_pkg::PC_NONDATA;
            acs_pkg::CMD_IDENTIFY, acs_pkg::CMD_IDENT_PKT, acs_pkg::CMD_READ_SECT:
              protocol_class_next = acs_pkg::PC_PIO_IN;
            acs_pkg::CMD_WRITE_SECT:
              protocol_class_next = acs_pkg::PC_PIO_OUT;
            acs_pkg::CMD_PACKET:
              protocol_class_next = acs_pkg::PC_PACKET;
            acs_pkg::CMD_DIAGNOSTIC:
              protocol_class_next = acs_pkg::PC_DIAG;
            default:
              protocol_class_next = acs_pkg::PC_UNKNOWN;
          endcase
          byte_count_low_next = 8'd0;
          if (item.command_code == acs_pkg::CMD_IDENTIFY ||
              item.command_code == acs_pkg::CMD_IDENT_PKT) begin
            words_left_next = acs_pkg::WORDS_W'(256);
          end else if (item.command_code == acs_pkg::CMD_READ_SECT ||
                       item.command_code == acs_pkg::CMD_WRITE_SECT) begin
            words_left_next = {sectors, 8'h00};
          end else begin
            words_left_next = '0;
          end
          phase_next      = acs_pkg::PH_BI_STAT;
          wait_ticks_next = 16'd0;
          res             = acs_pkg::mk_read(acs_pkg::REG_STATUS);
        end
      end

      acs_pkg::OPC_REPLY: begin
        case (phase)
          acs_pkg::PH_BI_STAT: begin
            if (v[acs_pkg::ST_BSY_BIT] || v[acs_pkg::ST_DRQ_BIT]) begin
              res = acs_pkg::mk_read(acs_pkg::REG_STATUS);
            end else begin
              phase_next = acs_pkg::PH_BI_DEV;
              res        = acs_pkg::mk_read(acs_pkg::REG_DEVHEAD);
            end
          end
          acs_pkg::PH_BI_DEV: begin
            wait_ticks_next = 16'd0;
            if (v[acs_pkg::DEV_BIT] != head[acs_pkg::DEV_BIT]) begin
              // Wrong drive selected: select it, then wait for idle again.
              kind       = acs_pkg::DK_RESEL;
              res        = acs_pkg::mk_write(acs_pkg::REG_DEVHEAD,
                                             head & 8'h10);
              phase_next = acs_pkg::PH_BI_STAT;
            end else begin
              kind       = acs_pkg::DK_TASKFILE;
              phase_next = acs_pkg::PH_CMD_STAT;
            end
          end
          acs_pkg::PH_CMD_STAT: begin
            if (v[acs_pkg::ST_BSY_BIT]) begin
              res = acs_pkg::mk_read(acs_pkg::REG_STATUS);
            end else begin
              phase_next = acs_pkg::PH_IDLE;
              case (protocol_class)
                acs_pkg::PC_PIO_IN, acs_pkg::PC_PIO_OUT: begin
                  if (!v[acs_pkg::ST_DRQ_BIT]) begin
                    res = acs_pkg::mk_done(protocol_class == acs_pkg::PC_PIO_IN ?
                                           acs_pkg::RC_DEV_ERR : err_code);
                  end else if (words_left == '0) begin
                    res = acs_pkg::mk_done(acs_pkg::RC_PHASE);
                  end else if (protocol_class == acs_pkg::PC_PIO_IN) begin
                    phase_next = acs_pkg::PH_XFER_IN;
                    res = acs_pkg::mk_xfer(acs_pkg::BOP_IN, blk_size[15:0]);
                  end else begin
                    phase_next = acs_pkg::PH_XFER_OUT;
                    res = acs_pkg::mk_xfer(acs_pkg::BOP_OUT, blk_size[15:0]);
                  end
                end
                acs_pkg::PC_PACKET: begin
                  if (v[acs_pkg::ST_DRQ_BIT]) begin
                    phase_next = acs_pkg::PH_PKT_REASON_A;
                    res        = acs_pkg::mk_read(acs_pkg::REG_IREASON);
                  end else begin
                    res = acs_pkg::mk_done(err_code);
                  end
                end
                acs_pkg::PC_DIAG: res = acs_pkg::mk_done(acs_pkg::RC_OK);
                default:          res = acs_pkg::mk_done(err_code);
              endcase
            end
          end
          acs_pkg::PH_IN_ALT: begin
            phase_next      = acs_pkg::PH_CMD_STAT;
            wait_ticks_next = 16'd0;
            res             = acs_pkg::mk_read(acs_pkg::REG_STATUS);
          end
          acs_pkg::PH_PKT_REASON_A: begin
            if (v[acs_pkg::IR_IO_BIT] || !v[acs_pkg::IR_COD_BIT]) begin
              phase_next = acs_pkg::PH_IDLE;
              res        = acs_pkg::mk_done(acs_pkg::RC_PHASE);
            end else begin
              phase_next = acs_pkg::PH_PKT_SEND;
              res        = acs_pkg::mk_xfer(acs_pkg::BOP_OUT, 16'(packet_words));
            end
          end
          acs_pkg::PH_PKT_ALT: begin
            phase_next      = acs_pkg::PH_PKT_STAT;
            wait_ticks_next = 16'd0;
            res             = acs_pkg::mk_read(acs_pkg::REG_STATUS);
          end
          acs_pkg::PH_PKT_STAT: begin
            if (v[acs_pkg::ST_BSY_BIT]) begin
              res = acs_pkg::mk_read(acs_pkg::REG_STATUS);
            end else if (v[acs_pkg::ST_DRQ_BIT]) begin
              phase_next = acs_pkg::PH_PKT_REASON_B;
              res        = acs_pkg::mk_read(acs_pkg::REG_IREASON);
            end else begin
              phase_next = acs_pkg::PH_IDLE;
              res        = acs_pkg::mk_done(err_code);
            end
          end
          acs_pkg::PH_PKT_REASON_B: begin
            if (v[acs_pkg::IR_COD_BIT]) begin
              phase_next = acs_pkg::PH_IDLE;
              res        = acs_pkg::mk_done(acs_pkg::RC_PHASE);
            end else begin
              phase_next = v[acs_pkg::IR_IO_BIT] ? acs_pkg::PH_PKT_BCL_IN
                                                 : acs_pkg::PH_PKT_BCL_OUT;
              res        = acs_pkg::mk_read(acs_pkg::REG_BCL);
            end
          end
          acs_pkg::PH_PKT_BCL_IN, acs_pkg::PH_PKT_BCL_OUT: begin
            byte_count_low_next = v;
            phase_next = (phase == acs_pkg::PH_PKT_BCL_IN) ? acs_pkg::PH_PKT_BCH_IN
                                                           : acs_pkg::PH_PKT_BCH_OUT;
            res        = acs_pkg::mk_read(acs_pkg::REG_BCH);
          end
          acs_pkg::PH_PKT_BCH_IN, acs_pkg::PH_PKT_BCH_OUT: begin
            // Byte count halved, rounding up, gives the word count.
            phase_next = acs_pkg::PH_PKT_XFER;
            res = acs_pkg::mk_xfer((phase == acs_pkg::PH_PKT_BCH_IN) ?
                                   acs_pkg::BOP_IN : acs_pkg::BOP_OUT,
                                   bc_round[16:1]);
          end
          default: ;
        endcase
      end

      acs_pkg::OPC_TICK: begin
        if (phase inside {acs_pkg::PH_BI_STAT, acs_pkg::PH_CMD_STAT,
                          acs_pkg::PH_PKT_STAT}) begin
          wait_ticks_next = ticks_inc;
          if (ticks_inc >= timeout_ticks) begin
            phase_next = acs_pkg::PH_IDLE;
            res        = acs_pkg::mk_done(acs_pkg::RC_TIMEOUT);
          end
        end
      end

      acs_pkg::OPC_XFER_DONE: begin
        case (phase)
          acs_pkg::PH_XFER_IN: begin
            words_left_next = words_after;
            if (words_after == '0) begin
              phase_next = acs_pkg::PH_IDLE;
              res        = acs_pkg::mk_done(acs_pkg::RC_OK);
            end else begin
              phase_next = acs_pkg::PH_IN_ALT;
              res        = acs_pkg::mk_read(acs_pkg::REG_ALT_STATUS);
            end
          end
          acs_pkg::PH_XFER_OUT: begin
            words_left_next = words_after;
            phase_next      = acs_pkg::PH_CMD_STAT;
            wait_ticks_next = 16'd0;
            res             = acs_pkg::mk_read(acs_pkg::REG_STATUS);
          end
          acs_pkg::PH_PKT_SEND, acs_pkg::PH_PKT_XFER: begin
            phase_next = acs_pkg::PH_PKT_ALT;
            res        = acs_pkg::mk_read(acs_pkg::REG_ALT_STATUS);
          end
          default: ;
        endcase
      end

      default: ;
    endcase

    desc = '{kind: kind, res: res, tf: taskfile};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= acs_pkg::TIMEOUT_RESET;
      packet_words   <= acs_pkg::PKT_WORDS_RESET;
      phase          <= acs_pkg::PH_IDLE;
      protocol_class <= acs_pkg::PC_UNKNOWN;
      words_left     <= '0;
      wait_ticks     <= 16'd0;
      taskfile       <= '0;
      byte_count_low <= 8'd0;
    end else begin
      if (cfg_we && cfg_index == acs_pkg::CFG_TIMEOUT) begin
        timeout_ticks <= cfg_data[15:0];
      end
      if (cfg_we && cfg_index == acs_pkg::CFG_PKT_WORDS) begin
        packet_words <= cfg_data[3:0];
      end
      if (accept) begin
        phase          <= phase_next;
        protocol_class <= protocol_class_next;
        words_left     <= words_left_next;
        wait_ticks     <= wait_ticks_next;
        taskfile       <= taskfile_next;
        byte_count_low <= byte_count_low_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/acs_emit.sv -----
// Result burst stage: holds one active burst and one waiting burst, and
// expands a burst into result items one per cycle while out_ready is high. Depends on acs_pkg.
`default_nettype none
module acs_emit (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  acs_pkg::desc_t  in_desc,
  output logic            out_valid,
  input  wire             out_ready,
  output acs_pkg::result_t out_res,
  output logic            out_last
);

  acs_pkg::desc_t   act, pend;
  logic             act_valid, pend_valid;
  logic [2:0]       idx;
  logic [2:0]       last_idx;
  logic             fire, act_free;
  logic [7:0][7:0]  tf_bytes;

  always_comb begin
    tf_bytes = {7'h00, act.tf};
    case (act.kind)
      acs_pkg::DK_SINGLE: begin
        last_idx = 3'd0;
        out_res  = act.res;
      end
      acs_pkg::DK_RESEL: begin
        last_idx = 3'd1;
        out_res  = (idx == 3'd0) ?
                   acs_pkg::mk_write(acs_pkg::REG_DEVHEAD, act.res.write_value) :
                   acs_pkg::mk_read(acs_pkg::REG_STATUS);
      end
      acs_pkg::DK_TASKFILE: begin
        // Features through command, then the first status poll.
        last_idx = 3'd7;
        out_res  = (idx == 3'd7) ? acs_pkg::mk_read(acs_pkg::REG_STATUS) :
                   acs_pkg::mk_write(4'(idx) + 4'd1, tf_bytes[idx]);
      end
      default: begin
        last_idx = 3'd0;
        out_res  = acs_pkg::mk_wait();
      end
    endcase
    out_last  = (idx == last_idx);
    out_valid = act_valid;
    fire      = act_valid && out_ready;
    act_free  = !act_valid || (fire && out_last);
    in_ready  = !pend_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= 3'd0;
    end else begin
      if (act_free) begin
        idx <= 3'd0;
        if (pend_valid) begin
          act        <= pend;
          act_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (in_valid) begin
          act       <= in_desc;
          act_valid <= 1'b1;
        end else begin
          act_valid <= 1'b0;
        end
      end else begin
        if (fire) begin
          idx <= idx + 3'd1;
        end
        if (in_valid) begin
          pend       <= in_desc;
          pend_valid <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ata_pio_command_sequencer_top.sv -----
// Top level of the ATA PIO command sequencer: stream ports, config port,
// and the acs_ctrl and acs_emit instances. Depends on acs_pkg.
//
// Usage: the slave stream carries input items (tuser holds the item kind:
// start, register read reply, timer tick, word transfer finished). The master
// stream carries bus operations for the host's register and data port logic;
// tlast marks the final result caused by one input item.
// Every input item causes at least one result: usually one, two when the
// drive must be reselected, and eight when the task file is written (seven
// register writes and the first status read).
// The first result of an item comes from the burst stage's registers, not
// straight from the input. Throughput is one item per cycle while each item
// causes one result and the receiver is ready; an item that causes a burst
// holds the single result port until its whole burst has been sent.
// One burst waits in a holding register behind the active one, so an item is
// accepted while a finished result is stalled by the receiver; s_tready only
// drops when that holding register is full.
// Reset (rst, synchronous) returns the sequencer to idle, clears its state,
// drops both bursts and restores timeout_ticks to 500 and packet_words to 6.
// Configuration writes take effect at the clock edge where cfg_we is high.
`default_nettype none
module ata_pio_command_sequencer_top #(
  parameter int BLOCK_WORDS = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // command_code[7:0], features[15:8], sector_count[23:16], lba[51:24],
  // drive[52], head_bits[60:53], reply_value[68:61], zero fill above
  input  wire [71:0]  s_tdata,
  // opcode[1:0]
  input  wire [1:0]   s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // bus_op[2:0], reg_index[6:3], write_value[14:7], word_count[30:15],
  // result_code[32:31], zero fill above
  output logic [39:0] m_tdata,
  output logic        m_tlast,
  input  wire         cfg_we,
  input  wire [acs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [acs_pkg::CFG_DATA_W-1:0] cfg_data
);

  acs_pkg::item_t   item;
  acs_pkg::desc_t   desc;
  acs_pkg::result_t res;
  logic             accept;

  always_comb begin
    item.opcode       = acs_pkg::opcode_t'(s_tuser);
    item.command_code = s_tdata[7:0];
    item.features     = s_tdata[15:8];
    item.sector_count = s_tdata[23:16];
    item.lba          = s_tdata[51:24];
    item.drive        = s_tdata[52];
    item.head_bits    = s_tdata[60:53];
    item.reply_value  = s_tdata[68:61];
  end

  // State advances at the same edge the item enters the burst stage.
  assign accept = s_tvalid && s_tready;

  acs_ctrl #(
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .desc      (desc)
  );

  acs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_tready),
    .in_desc   (desc),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res),
    .out_last  (m_tlast)
  );

  assign m_tdata = {7'd0, res.result_code, res.word_count, res.write_value,
                    res.reg_index, res.op};

endmodule
`default_nettype wire
